[src/tac_pkg.sv]
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants for the timer and interrupt controller: request
// and register codes, item payload structs, edge taps and vector base.
// ----------------------------------------------------------------------------
package tac_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_READ  = 3'd2,
    REQ_RAISE = 3'd3,
    REQ_POLL  = 3'd4
  } req_type_e;

  // Register select codes
  typedef enum logic [2:0] {
    REG_COUNT   = 3'd0,
    REG_RELOAD  = 3'd1,
    REG_CONTROL = 3'd2,
    REG_FLAGS   = 3'd3,
    REG_ENABLES = 3'd4
  } reg_sel_e;

  // Counter bit tapped for each timer rate select
  localparam int EdgeBitSel0 = 9;
  localparam int EdgeBitSel1 = 3;
  localparam int EdgeBitSel2 = 5;
  localparam int EdgeBitSel3 = 7;

  // Timer control layout
  localparam int CtrlEnableBit = 2;

  // Flag bit raised by a timer reload
  localparam int TimerIrqBit = 2;

  // Counter units added by one serviced interrupt
  localparam logic [7:0] PollTicks = 8'd20;

  localparam logic [7:0] CountMax   = 8'd255;
  localparam logic [6:0] VectorBase = 7'h40;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] mcycles;
    logic [2:0] reg_sel;
    logic [7:0] write_data;
    logic [2:0] irq_number;
    logic       master_enable;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_taken;
    logic [6:0] vector;
    logic       timer_overflow;
  } out_item_t;

endpackage

[src/timer_and_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// timer_and_interrupt_controller
// Free-running cycle counter with a falling-edge driven timer, reload and
// interrupt flag, register access and lowest-first interrupt servicing.
// ----------------------------------------------------------------------------
// Flow: an accepted item passes the input register, then the result register;
//   every item gives exactly one result.
// Throughput: one item per cycle; the single pass of logic between the input
//   register and the result register updates all state in that cycle. A result
//   held by out_ready_i low stalls the item waiting behind it.
// Reset: rst_ni clears both pipeline valids and every timer and interrupt
//   register to zero.
module timer_and_interrupt_controller
  import tac_pkg::*;
#(
  parameter int NUM_SOURCES  = 5,
  parameter int COUNTER_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int SrcCmpBits = 4;

  // Pipeline registers
  logic      in_valid_q;
  in_item_t  item_q;
  logic      out_valid_q;
  out_item_t res_q;
  out_item_t res_d;
  logic      proc_fire;

  // Architectural state
  logic [COUNTER_BITS-1:0] cycle_counter_q, cycle_counter_d;
  logic [7:0]              timer_count_q, timer_count_d;
  logic [7:0]              timer_reload_q, timer_reload_d;
  logic [2:0]              timer_control_q, timer_control_d;
  logic [7:0]              irq_flags_q, irq_flags_d;
  logic [7:0]              irq_enables_q, irq_enables_d;

  // Datapath intermediates
  logic                    src_found;
  logic [2:0]              src_idx;
  logic                    do_advance;
  logic [7:0]              adv_amount;
  logic [COUNTER_BITS-1:0] counter_sum;
  logic                    tap_before, tap_after;
  logic                    timer_step;
  logic                    overflow;

  assign proc_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;

  // Pick the lowest pending and enabled source
  always_comb begin
    src_found = 1'b0;
    src_idx   = 3'd0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (irq_flags_q[i] && irq_enables_q[i]) begin
        src_found = 1'b1;
        src_idx   = 3'(i);
      end
    end
  end

  // Advance the counter and detect a falling edge on the selected tap
  always_comb begin
    do_advance = 1'b0;
    adv_amount = {item_q.mcycles, 2'b00};
    if (item_q.req_type == REQ_TICK) begin
      do_advance = 1'b1;
    end else if (item_q.req_type == REQ_POLL && item_q.master_enable && src_found) begin
      do_advance = 1'b1;
      adv_amount = PollTicks;
    end
    counter_sum = cycle_counter_q + COUNTER_BITS'(adv_amount);
    case (timer_control_q[1:0])
      2'd0: begin
        tap_before = cycle_counter_q[EdgeBitSel0];
        tap_after  = counter_sum[EdgeBitSel0];
      end
      2'd1: begin
        tap_before = cycle_counter_q[EdgeBitSel1];
        tap_after  = counter_sum[EdgeBitSel1];
      end
      2'd2: begin
        tap_before = cycle_counter_q[EdgeBitSel2];
        tap_after  = counter_sum[EdgeBitSel2];
      end
      default: begin
        tap_before = cycle_counter_q[EdgeBitSel3];
        tap_after  = counter_sum[EdgeBitSel3];
      end
    endcase
    timer_step = do_advance && timer_control_q[CtrlEnableBit] && tap_before && !tap_after;
    overflow   = timer_step && (timer_count_q == CountMax);
  end

  // Next state and result for the item in the input register
  always_comb begin
    cycle_counter_d = cycle_counter_q;
    timer_count_d   = timer_count_q;
    timer_reload_d  = timer_reload_q;
    timer_control_d = timer_control_q;
    irq_flags_d     = irq_flags_q;
    irq_enables_d   = irq_enables_q;
    res_d           = '0;

    unique case (item_q.req_type)
      REQ_WRITE: begin
        unique case (item_q.reg_sel)
          REG_COUNT:   timer_count_d   = item_q.write_data;
          REG_RELOAD:  timer_reload_d  = item_q.write_data;
          REG_CONTROL: timer_control_d = item_q.write_data[2:0];
          REG_FLAGS:   irq_flags_d     = item_q.write_data;
          REG_ENABLES: irq_enables_d   = item_q.write_data;
          default: ;
        endcase
      end
      REQ_READ: begin
        unique case (item_q.reg_sel)
          REG_COUNT:   res_d.read_data = timer_count_q;
          REG_RELOAD:  res_d.read_data = timer_reload_q;
          REG_CONTROL: res_d.read_data = {5'b0, timer_control_q};
          REG_FLAGS:   res_d.read_data = irq_flags_q;
          REG_ENABLES: res_d.read_data = irq_enables_q;
          default:     res_d.read_data = 8'd0;
        endcase
      end
      REQ_RAISE: begin
        if ({1'b0, item_q.irq_number} < SrcCmpBits'(NUM_SOURCES)) begin
          irq_flags_d = irq_flags_q | (8'd1 << item_q.irq_number);
        end
      end
      REQ_POLL: begin
        if (item_q.master_enable && src_found) begin
          irq_flags_d     = irq_flags_q & ~(8'd1 << src_idx);
          res_d.irq_taken = 1'b1;
          res_d.vector    = VectorBase + {1'b0, src_idx, 3'b000};
        end
      end
      default: ;
    endcase

    // Counter advance from a tick or a serviced poll
    if (do_advance) begin
      cycle_counter_d = counter_sum;
      if (overflow) begin
        timer_count_d              = timer_reload_q;
        irq_flags_d[TimerIrqBit]   = 1'b1;
        res_d.timer_overflow       = 1'b1;
      end else if (timer_step) begin
        timer_count_d = timer_count_q + 8'd1;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      res_q <= res_d;
    end
  end

  // Timer and interrupt state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_counter_q <= '0;
      timer_count_q   <= '0;
      timer_reload_q  <= '0;
      timer_control_q <= '0;
      irq_flags_q     <= '0;
      irq_enables_q   <= '0;
    end else if (proc_fire) begin
      cycle_counter_q <= cycle_counter_d;
      timer_count_q   <= timer_count_d;
      timer_reload_q  <= timer_reload_d;
      timer_control_q <= timer_control_d;
      irq_flags_q     <= irq_flags_d;
      irq_enables_q   <= irq_enables_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // A reload always leaves the timer flag raised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && overflow |=> irq_flags_q[TimerIrqBit])
    else $error("timer reload did not raise the timer flag");

  // The counter moves only when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_fire |=> $stable(cycle_counter_q))
    else $error("cycle counter changed without an item");

  // A served interrupt carries a vector in the handler range, else none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.irq_taken ? out_item_o.vector[6]
                                          : (out_item_o.vector == 7'd0)))
    else $error("vector does not match irq_taken");

  // The timer steps only on a tick or a serviced poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_step |-> (item_q.req_type == REQ_TICK || item_q.req_type == REQ_POLL))
    else $error("timer stepped on a non-advancing request");

endmodule
